FILE: rtl/lzom_pkg.sv
`timescale 1ns / 1ps
// lzom_pkg: shared types and constants for the layer z-order manager.
// No dependencies; used by the channel interfaces, lzom_cell and the top level.

package lzom_pkg;

   localparam int MAX_LAYERS_DEF = 16;
   localparam int COORD_BITS_DEF = 16;

   localparam int KIND_W = 3;
   localparam int ID_W   = 8;
   localparam int POS_W  = 16;
   localparam int HGT_W  = 9;
   localparam int STAT_W = 2;
   localparam int IDX_W  = 8;

   localparam logic [KIND_W-1:0] KIND_CREATE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MOVE_ABS = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE_REL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HEIGHT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_HIDE     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DRAW     = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOVE_WR,
      ST_SCAN,
      ST_EDIT,
      ST_RESP,
      ST_DRAW_RD,
      ST_DRAW_OUT
   } lzom_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_SCAN,
      CELL_REMOVE,
      CELL_INSERT,
      CELL_MOVE,
      CELL_ROTATE
   } lzom_cell_op_type;

   typedef struct packed {
      lzom_cell_op_type  op;
      logic [ID_W-1:0]   id;
      logic [IDX_W-1:0]  pos;
      logic [IDX_W-1:0]  count;
      logic [ID_W-1:0]   bottom_id;
   } lzom_cell_cmd_type;

endpackage

FILE: rtl/lzom_req_if.sv
`timescale 1ns / 1ps
// lzom_req_if: request channel (valid/ready plus one command word).
// Depends on lzom_pkg for field widths.

interface lzom_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [lzom_pkg::KIND_W-1:0]     kind;
   logic        [lzom_pkg::ID_W-1:0]       layer_id;
   logic signed [lzom_pkg::POS_W-1:0]      pos_x;
   logic signed [lzom_pkg::POS_W-1:0]      pos_y;
   logic signed [lzom_pkg::HGT_W-1:0]      height;

   modport source (output valid, kind, layer_id, pos_x, pos_y, height, input ready);
   modport sink   (input valid, kind, layer_id, pos_x, pos_y, height, output ready);
endinterface

FILE: rtl/lzom_rsp_if.sv
`timescale 1ns / 1ps
// lzom_rsp_if: response channel (valid/ready plus one result word).
// Depends on lzom_pkg for field widths.

interface lzom_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [lzom_pkg::ID_W-1:0]       out_id;
   logic signed [lzom_pkg::POS_W-1:0]      out_x;
   logic signed [lzom_pkg::POS_W-1:0]      out_y;
   logic        [lzom_pkg::STAT_W-1:0]     status;
   logic                                   last;

   modport source (output valid, out_id, out_x, out_y, status, last, input ready);
   modport sink   (input valid, out_id, out_x, out_y, status, last, output ready);
endinterface

FILE: rtl/lzom_cell.sv
`timescale 1ns / 1ps
// lzom_cell: one slot of the z-order stack; holds a layer id and a
// "match below" flag that ripples up one cell per cycle during a scan. Depends on lzom_pkg.

module lzom_cell #(
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lzom_pkg::lzom_cell_cmd_type     cmd,
   input  logic [lzom_pkg::ID_W-1:0]       lower_id,
   input  logic [lzom_pkg::ID_W-1:0]       upper_id,
   input  logic                            chain_in,
   output logic [lzom_pkg::ID_W-1:0]       id_out,
   output logic                            chain_out
);

   localparam logic [lzom_pkg::IDX_W-1:0] IDX = lzom_pkg::IDX_W'(INDEX);

   logic [lzom_pkg::ID_W-1:0] id_ff, id_in;
   logic                      below_ff, below_in;
   logic                      match;
   logic                      at_above;

   assign match     = (IDX < cmd.count) && (id_ff == cmd.id);
   assign at_above  = below_ff || match;
   assign chain_out = at_above;
   assign id_out    = id_ff;

   always_comb begin
      id_in    = id_ff;
      below_in = below_ff;
      unique case (cmd.op)
         lzom_pkg::CELL_HOLD: begin
         end
         lzom_pkg::CELL_CLEAR: begin
            below_in = 1'b0;
         end
         lzom_pkg::CELL_SCAN: begin
            below_in = chain_in;
         end
         lzom_pkg::CELL_REMOVE: begin
            id_in = at_above ? upper_id : id_ff;
         end
         lzom_pkg::CELL_INSERT: begin
            if (IDX == cmd.pos) begin
               id_in = cmd.id;
            end else if (IDX < cmd.pos) begin
               id_in = id_ff;
            end else begin
               id_in = lower_id;
            end
         end
         lzom_pkg::CELL_MOVE: begin
            // remove at the matching slot, then insert at pos
            if (IDX == cmd.pos) begin
               id_in = cmd.id;
            end else if (IDX < cmd.pos) begin
               id_in = at_above ? upper_id : id_ff;
            end else begin
               id_in = below_ff ? id_ff : lower_id;
            end
         end
         lzom_pkg::CELL_ROTATE: begin
            id_in = (IDX == cmd.pos) ? cmd.bottom_id : upper_id;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         below_ff <= 1'b0;
      end else begin
         below_ff <= below_in;
      end
   end

endmodule

FILE: rtl/lzom_pos_mem.sv
`timescale 1ns / 1ps
// lzom_pos_mem: layer position table, one write and one registered read port.
// Standalone; no package dependencies.

module lzom_pos_mem #(
   parameter  int DEPTH  = 16,
   parameter  int WIDTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/layer_z_order_manager_top.sv
`timescale 1ns / 1ps
// layer_z_order_manager_top: layer table and bottom-to-top z-order stack.
// Depends on lzom_pkg, lzom_req_if, lzom_rsp_if, lzom_cell, lzom_pos_mem.
//
// req_ch carries one command word per handshake (create, move absolute,
// move relative, set height, hide, draw); rsp_ch returns result words, the
// final one of each command flagged by last. Commands are taken one at a
// time: req_ch.ready is high only while no command is in progress.
// Steps per command, accept to next accept:
//   create, unknown id, unused kind, empty draw: execute, then respond
//   move absolute / relative: read-modify-write of the position table
//   set height / hide: match flag ripples up the cell row one slot per
//     cycle, then the cells shift in a single edit step
//   draw: per stacked layer, a position read, then output and rotate
// Reset clears the layer and stack counts; position entries need no clearing
// pass since each is written to zero when its layer is created.
// A result waits in the output register while rsp_ch.ready is low; the next
// command is still accepted, and a draw pauses until each word is taken.

module layer_z_order_manager_top #(
   parameter int MAX_LAYERS = lzom_pkg::MAX_LAYERS_DEF,
   parameter int COORD_BITS = lzom_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lzom_req_if.sink   req_ch,
   lzom_rsp_if.source rsp_ch
);

   localparam int CNT_W  = $clog2(MAX_LAYERS + 1);
   localparam int ADDR_W = $clog2(MAX_LAYERS);
   localparam int MEM_W  = 2 * COORD_BITS;
   localparam int SUM_W  = ((COORD_BITS > lzom_pkg::POS_W) ? COORD_BITS : lzom_pkg::POS_W) + 1;
   localparam logic signed [SUM_W-1:0] CMAX =
      {{(SUM_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] CMIN = ~CMAX;

   lzom_pkg::lzom_state_type state_ff, state_in;

   logic        [lzom_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic        [lzom_pkg::ID_W-1:0]   id_ff, id_in;
   logic signed [lzom_pkg::POS_W-1:0]  px_ff, px_in;
   logic signed [lzom_pkg::POS_W-1:0]  py_ff, py_in;
   logic signed [lzom_pkg::HGT_W-1:0]  h_ff, h_in;

   logic [CNT_W-1:0] created_ff, created_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] draw_ff, draw_in;

   logic [lzom_pkg::ID_W-1:0]   res_id_ff, res_id_in;
   logic [lzom_pkg::STAT_W-1:0] res_status_ff, res_status_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic        [lzom_pkg::ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic signed [lzom_pkg::POS_W-1:0]  rsp_x_ff, rsp_x_in;
   logic signed [lzom_pkg::POS_W-1:0]  rsp_y_ff, rsp_y_in;
   logic        [lzom_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic accept;
   logic rsp_free;
   logic id_valid;
   logic is_create, is_draw, is_unused, is_move;
   logic present, remove_req, last_draw;

   logic [lzom_pkg::IDX_W-1:0] h8, count8, count_m1, ins_pos, mov_pos;
   logic [lzom_pkg::ID_W-1:0]  bottom_id;
   logic [ADDR_W-1:0]          id_addr;

   lzom_pkg::lzom_cell_cmd_type cmd;
   logic [lzom_pkg::ID_W-1:0]   cell_id  [MAX_LAYERS];
   logic [lzom_pkg::ID_W-1:0]   lower_id [MAX_LAYERS];
   logic [lzom_pkg::ID_W-1:0]   upper_id [MAX_LAYERS];
   logic [MAX_LAYERS-1:0]       chain;
   logic [MAX_LAYERS-1:0]       below_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [MEM_W-1:0]  wr_data, rd_data;

   logic signed [COORD_BITS-1:0] rd_x, rd_y;
   logic signed [SUM_W-1:0]      base_x, base_y, sum_x, sum_y, sat_x, sat_y;

   // ---------------------------------------------------------------- cells
   for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_cell
      if (g == 0) begin : g_lo
         assign lower_id[g] = '0;
         assign below_in[g] = 1'b0;
      end else begin : g_lo
         assign lower_id[g] = cell_id[g-1];
         assign below_in[g] = chain[g-1];
      end
      if (g == MAX_LAYERS - 1) begin : g_hi
         assign upper_id[g] = '0;
      end else begin : g_hi
         assign upper_id[g] = cell_id[g+1];
      end

      lzom_cell #(
         .INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .lower_id  (lower_id[g]),
         .upper_id  (upper_id[g]),
         .chain_in  (below_in[g]),
         .id_out    (cell_id[g]),
         .chain_out (chain[g])
      );
   end

   lzom_pos_mem #(
      .DEPTH (MAX_LAYERS),
      .WIDTH (MEM_W)
   ) u_pos_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------- decode
   assign req_ch.ready = (state_ff == lzom_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign id_valid  = (id_ff != '0) && ({1'b0, id_ff} <= 9'(created_ff));
   assign is_create = (kind_ff == lzom_pkg::KIND_CREATE);
   assign is_draw   = (kind_ff == lzom_pkg::KIND_DRAW);
   assign is_unused = (kind_ff > lzom_pkg::KIND_DRAW);
   assign is_move   = (kind_ff == lzom_pkg::KIND_MOVE_ABS) ||
                      (kind_ff == lzom_pkg::KIND_MOVE_REL);

   assign present    = chain[MAX_LAYERS-1];
   assign remove_req = (kind_ff == lzom_pkg::KIND_HIDE) || h_ff[lzom_pkg::HGT_W-1];
   assign h8         = h_ff[lzom_pkg::IDX_W-1:0];
   assign count8     = lzom_pkg::IDX_W'(count_ff);
   assign count_m1   = count8 - lzom_pkg::IDX_W'(1);
   assign ins_pos    = (h8 < count8) ? h8 : count8;
   assign mov_pos    = (h8 < count_m1) ? h8 : count_m1;
   assign bottom_id  = cell_id[0];
   assign last_draw  = (draw_ff == count_ff - CNT_W'(1));
   assign id_addr    = ADDR_W'(id_ff - lzom_pkg::ID_W'(1));

   assign rd_x = rd_data[MEM_W-1:COORD_BITS];
   assign rd_y = rd_data[COORD_BITS-1:0];

   assign base_x = (kind_ff == lzom_pkg::KIND_MOVE_REL) ? SUM_W'(rd_x) : '0;
   assign base_y = (kind_ff == lzom_pkg::KIND_MOVE_REL) ? SUM_W'(rd_y) : '0;
   assign sum_x  = base_x + SUM_W'(px_ff);
   assign sum_y  = base_y + SUM_W'(py_ff);
   assign sat_x  = (sum_x > CMAX) ? CMAX : ((sum_x < CMIN) ? CMIN : sum_x);
   assign sat_y  = (sum_y > CMAX) ? CMAX : ((sum_y < CMIN) ? CMIN : sum_y);

   // --------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzom_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lzom_pkg::ST_EXEC;
            end
         end
         lzom_pkg::ST_EXEC: begin
            priority if (is_draw && count_ff != '0) begin
               state_in = lzom_pkg::ST_DRAW_RD;
            end else if (is_create || is_draw || is_unused || !id_valid) begin
               state_in = lzom_pkg::ST_RESP;
            end else if (is_move) begin
               state_in = lzom_pkg::ST_MOVE_WR;
            end else begin
               state_in = lzom_pkg::ST_SCAN;
            end
         end
         lzom_pkg::ST_MOVE_WR: begin
            state_in = lzom_pkg::ST_RESP;
         end
         lzom_pkg::ST_SCAN: begin
            if (scan_ff == CNT_W'(MAX_LAYERS - 2)) begin
               state_in = lzom_pkg::ST_EDIT;
            end
         end
         lzom_pkg::ST_EDIT: begin
            state_in = lzom_pkg::ST_RESP;
         end
         lzom_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = lzom_pkg::ST_IDLE;
            end
         end
         lzom_pkg::ST_DRAW_RD: begin
            state_in = lzom_pkg::ST_DRAW_OUT;
         end
         lzom_pkg::ST_DRAW_OUT: begin
            if (rsp_free) begin
               state_in = last_draw ? lzom_pkg::ST_IDLE : lzom_pkg::ST_DRAW_RD;
            end
         end
      endcase
   end

   // ------------------------------------------------------------ outputs
   always_comb begin
      kind_in = accept ? req_ch.kind     : kind_ff;
      id_in   = accept ? req_ch.layer_id : id_ff;
      px_in   = accept ? req_ch.pos_x    : px_ff;
      py_in   = accept ? req_ch.pos_y    : py_ff;
      h_in    = accept ? req_ch.height   : h_ff;

      created_in    = created_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      draw_in       = draw_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      cmd.op        = lzom_pkg::CELL_HOLD;
      cmd.id        = id_ff;
      cmd.pos       = '0;
      cmd.count     = count8;
      cmd.bottom_id = bottom_id;

      wr_en   = 1'b0;
      wr_addr = id_addr;
      wr_data = {COORD_BITS'(sat_x), COORD_BITS'(sat_y)};
      rd_en   = 1'b0;
      rd_addr = id_addr;

      unique case (state_ff)
         lzom_pkg::ST_IDLE: begin
         end
         lzom_pkg::ST_EXEC: begin
            priority if (is_create) begin
               if (created_ff == CNT_W'(MAX_LAYERS)) begin
                  res_id_in     = '0;
                  res_status_in = lzom_pkg::STAT_FULL;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = ADDR_W'(created_ff);
                  wr_data       = '0;
                  created_in    = created_ff + CNT_W'(1);
                  res_id_in     = lzom_pkg::ID_W'(created_ff + CNT_W'(1));
                  res_status_in = lzom_pkg::STAT_OK;
               end
            end else if (is_draw) begin
               draw_in       = '0;
               res_id_in     = '0;
               res_status_in = lzom_pkg::STAT_EMPTY;
            end else if (is_unused) begin
               res_id_in     = '0;
               res_status_in = lzom_pkg::STAT_OK;
            end else if (!id_valid) begin
               res_id_in     = id_ff;
               res_status_in = lzom_pkg::STAT_UNKNOWN;
            end else if (is_move) begin
               rd_en = 1'b1;
            end else begin
               cmd.op  = lzom_pkg::CELL_CLEAR;
               scan_in = '0;
            end
         end
         lzom_pkg::ST_MOVE_WR: begin
            wr_en         = 1'b1;
            res_id_in     = id_ff;
            res_status_in = lzom_pkg::STAT_OK;
         end
         lzom_pkg::ST_SCAN: begin
            cmd.op  = lzom_pkg::CELL_SCAN;
            scan_in = scan_ff + CNT_W'(1);
         end
         lzom_pkg::ST_EDIT: begin
            res_id_in     = id_ff;
            res_status_in = lzom_pkg::STAT_OK;
            priority if (remove_req) begin
               if (present) begin
                  cmd.op   = lzom_pkg::CELL_REMOVE;
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (!present) begin
               if (count_ff < CNT_W'(MAX_LAYERS)) begin
                  cmd.op   = lzom_pkg::CELL_INSERT;
                  cmd.pos  = ins_pos;
                  count_in = count_ff + CNT_W'(1);
               end
            end else begin
               cmd.op  = lzom_pkg::CELL_MOVE;
               cmd.pos = mov_pos;
            end
         end
         lzom_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_status_in = res_status_ff;
               rsp_last_in   = 1'b1;
            end
         end
         lzom_pkg::ST_DRAW_RD: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(bottom_id - lzom_pkg::ID_W'(1));
         end
         lzom_pkg::ST_DRAW_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = bottom_id;
               rsp_x_in      = lzom_pkg::POS_W'(rd_x);
               rsp_y_in      = lzom_pkg::POS_W'(rd_y);
               rsp_status_in = lzom_pkg::STAT_OK;
               rsp_last_in   = last_draw;
               cmd.op        = lzom_pkg::CELL_ROTATE;
               cmd.pos       = count_m1;
               draw_in       = draw_ff + CNT_W'(1);
            end
         end
      endcase
   end

   // ---------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzom_pkg::ST_IDLE;
         created_ff   <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         draw_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         created_ff   <= created_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         draw_ff      <= draw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      h_ff          <= h_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.out_id = rsp_id_ff;
   assign rsp_ch.out_x  = rsp_x_ff;
   assign rsp_ch.out_y  = rsp_y_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.last   = rsp_last_ff;

`ifndef SYNTHESIS
   a_stack_le_created: assert property (@(posedge clock) disable iff (reset)
      count_ff <= created_ff)
      else $error("stack holds more layers than were created");

   a_created_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> created_ff >= $past(created_ff))
      else $error("created layer count went down");

   a_count_only_in_edit: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && count_ff != $past(count_ff)) |-> $past(state_ff == lzom_pkg::ST_EDIT))
      else $error("stack count changed outside an edit");

   a_multi_only_draw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (kind_ff == lzom_pkg::KIND_DRAW))
      else $error("non-final word from a command other than draw");
`endif

endmodule

FILE: verif/layer_z_order_manager_top_tb.sv
`timescale 1ns / 1ps
// layer_z_order_manager_top_tb: self-checking bench for the layer z-order manager.
// Depends on lzom_pkg, lzom_req_if, lzom_rsp_if and the rtl under rtl/.

module layer_z_order_manager_top_tb;

   localparam int MAX_LAYERS     = lzom_pkg::MAX_LAYERS_DEF;
   localparam int COORD_MAX      = 2 ** (lzom_pkg::POS_W - 1) - 1;
   localparam int COORD_MIN      = -COORD_MAX - 1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;

   localparam logic [lzom_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [lzom_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

   localparam logic signed [lzom_pkg::POS_W-1:0] POS_HI = lzom_pkg::POS_W'(COORD_MAX);
   localparam logic signed [lzom_pkg::POS_W-1:0] POS_LO = lzom_pkg::POS_W'(COORD_MIN);

   typedef struct {
      logic        [lzom_pkg::ID_W-1:0]   id;
      logic signed [lzom_pkg::POS_W-1:0]  x;
      logic signed [lzom_pkg::POS_W-1:0]  y;
      logic        [lzom_pkg::STAT_W-1:0] status;
      logic                               last;
   } layer_word_type;

   logic clock = 1'b0;
   logic reset;

   lzom_req_if req_ch ();
   lzom_rsp_if rsp_ch ();

   layer_z_order_manager_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the layer table and z-order stack
   logic        [lzom_pkg::ID_W-1:0]  zorder [$];
   logic signed [lzom_pkg::POS_W-1:0] layer_x [MAX_LAYERS];
   logic signed [lzom_pkg::POS_W-1:0] layer_y [MAX_LAYERS];
   int                                layers_made = 0;

   layer_word_type owed_words [$];
   int             failures    = 0;
   int             quiet_cycles = 0;
   int             stall_left  = 0;
   bit             idling      = 1'b1;

   function automatic logic signed [lzom_pkg::POS_W-1:0] clamp_coord(input int v);
      if (v > COORD_MAX) return POS_HI;
      if (v < COORD_MIN) return POS_LO;
      return lzom_pkg::POS_W'(v);
   endfunction

   task automatic predict_layer_words(input logic        [lzom_pkg::KIND_W-1:0] kind,
                                      input logic        [lzom_pkg::ID_W-1:0]   lid,
                                      input logic signed [lzom_pkg::POS_W-1:0]  px,
                                      input logic signed [lzom_pkg::POS_W-1:0]  py,
                                      input logic signed [lzom_pkg::HGT_W-1:0]  hgt);
      layer_word_type w;
      bit             single;
      int             slot;
      int             where;
      int             limit;
      w = '{default: '0};
      w.last = 1'b1;
      single = 1'b1;
      unique case (kind)
         lzom_pkg::KIND_CREATE: begin
            if (layers_made >= MAX_LAYERS) begin
               w.status = lzom_pkg::STAT_FULL;
            end else begin
               layers_made++;
               w.id = lzom_pkg::ID_W'(layers_made);
            end
         end
         lzom_pkg::KIND_DRAW: begin
            if (zorder.size() == 0) begin
               w.status = lzom_pkg::STAT_EMPTY;
            end else begin
               for (int i = 0; i < zorder.size(); i++) begin
                  w.id   = zorder[i];
                  w.x    = layer_x[zorder[i] - 1];
                  w.y    = layer_y[zorder[i] - 1];
                  w.last = (i == zorder.size() - 1);
                  owed_words.push_back(w);
               end
               single = 1'b0;
            end
         end
         lzom_pkg::KIND_MOVE_ABS, lzom_pkg::KIND_MOVE_REL,
         lzom_pkg::KIND_HEIGHT, lzom_pkg::KIND_HIDE: begin
            w.id = lid;
            slot = int'(lid) - 1;
            if (lid == 0 || int'(lid) > layers_made) begin
               w.status = lzom_pkg::STAT_UNKNOWN;
            end else if (kind == lzom_pkg::KIND_MOVE_ABS) begin
               layer_x[slot] = px;
               layer_y[slot] = py;
            end else if (kind == lzom_pkg::KIND_MOVE_REL) begin
               layer_x[slot] = clamp_coord(int'(layer_x[slot]) + int'(px));
               layer_y[slot] = clamp_coord(int'(layer_y[slot]) + int'(py));
            end else begin
               where = -1;
               foreach (zorder[i]) if (zorder[i] == lid) where = i;
               if (where >= 0) zorder.delete(where);
               // after removal the clamp is the same for present and absent layers
               if (kind == lzom_pkg::KIND_HEIGHT && hgt >= 0) begin
                  limit = zorder.size();
                  zorder.insert((int'(hgt) < limit) ? int'(hgt) : limit, lid);
               end
            end
         end
         default: ;
      endcase
      if (single) owed_words.push_back(w);
   endtask

   task automatic issue_command(input logic        [lzom_pkg::KIND_W-1:0] kind,
                                input logic        [lzom_pkg::ID_W-1:0]   lid,
                                input logic signed [lzom_pkg::POS_W-1:0]  px,
                                input logic signed [lzom_pkg::POS_W-1:0]  py,
                                input logic signed [lzom_pkg::HGT_W-1:0]  hgt);
      predict_layer_words(kind, lid, px, py, hgt);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= kind;
      req_ch.layer_id <= lid;
      req_ch.pos_x    <= px;
      req_ch.pos_y    <= py;
      req_ch.height   <= hgt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic issue_noise(input logic [lzom_pkg::KIND_W-1:0] kind);
      issue_command(kind, lzom_pkg::ID_W'($urandom), lzom_pkg::POS_W'($urandom),
                    lzom_pkg::POS_W'($urandom), lzom_pkg::HGT_W'($urandom));
   endtask

   task automatic test_empty_state();
      issue_noise(lzom_pkg::KIND_DRAW);
      issue_command(lzom_pkg::KIND_HIDE, 0, 0, 0, 0);
      issue_command(lzom_pkg::KIND_MOVE_REL, 255, 1, 1, 0);
      issue_command(lzom_pkg::KIND_HEIGHT, 1, 0, 0, 0);
      issue_noise(KIND_SPARE_A);
      issue_noise(KIND_SPARE_B);
   endtask

   task automatic test_create_layers();
      repeat (3) issue_noise(lzom_pkg::KIND_CREATE);
   endtask

   task automatic test_position_moves();
      issue_command(lzom_pkg::KIND_MOVE_ABS, 1, POS_LO, POS_HI, 0);
      issue_command(lzom_pkg::KIND_MOVE_REL, 1, -5, 5, 0);
      issue_command(lzom_pkg::KIND_MOVE_REL, 1, POS_HI, POS_LO, 0);
      issue_command(lzom_pkg::KIND_MOVE_ABS, 4, 7, 7, 0);
      issue_command(lzom_pkg::KIND_MOVE_ABS, 2, 1234, -4321, 0);
   endtask

   task automatic test_stack_order();
      issue_command(lzom_pkg::KIND_HEIGHT, 1, 0, 0, 255);
      issue_command(lzom_pkg::KIND_HEIGHT, 2, 0, 0, 0);
      issue_command(lzom_pkg::KIND_HEIGHT, 3, 0, 0, 1);
      issue_command(lzom_pkg::KIND_HEIGHT, 2, 0, 0, 255);
      issue_command(lzom_pkg::KIND_DRAW, 0, 0, 0, 0);
      issue_command(lzom_pkg::KIND_HEIGHT, 1, 0, 0, -256);
      issue_command(lzom_pkg::KIND_HEIGHT, 1, 0, 0, -1);
      issue_command(lzom_pkg::KIND_HIDE, 1, 0, 0, 0);
      issue_command(lzom_pkg::KIND_HEIGHT, 1, 0, 0, 0);
      issue_command(lzom_pkg::KIND_HIDE, 3, 0, 0, 0);
      issue_command(lzom_pkg::KIND_DRAW, 0, 0, 0, 0);
   endtask

   task automatic test_random_traffic(input int count, input bit with_gaps);
      int                                pick;
      logic        [lzom_pkg::KIND_W-1:0] kind;
      logic        [lzom_pkg::ID_W-1:0]   lid;
      logic signed [lzom_pkg::POS_W-1:0]  px;
      logic signed [lzom_pkg::POS_W-1:0]  py;
      logic signed [lzom_pkg::HGT_W-1:0]  hgt;
      idling = with_gaps;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)       kind = lzom_pkg::KIND_CREATE;
         else if (pick < 20) kind = lzom_pkg::KIND_MOVE_ABS;
         else if (pick < 32) kind = lzom_pkg::KIND_MOVE_REL;
         else if (pick < 62) kind = lzom_pkg::KIND_HEIGHT;
         else if (pick < 74) kind = lzom_pkg::KIND_HIDE;
         else if (pick < 95) kind = lzom_pkg::KIND_DRAW;
         else                kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
         if (layers_made > 0 && $urandom_range(0, 9) != 0)
            lid = lzom_pkg::ID_W'($urandom_range(1, layers_made));
         else
            lid = lzom_pkg::ID_W'($urandom);
         px = lzom_pkg::POS_W'($urandom);
         py = lzom_pkg::POS_W'($urandom);
         if (kind == lzom_pkg::KIND_MOVE_REL && $urandom_range(0, 3) == 0) begin
            px = $urandom_range(0, 1) ? POS_HI : POS_LO;
            py = $urandom_range(0, 1) ? POS_HI : POS_LO;
         end
         pick = $urandom_range(0, 9);
         if (pick < 7)      hgt = lzom_pkg::HGT_W'($urandom_range(0, MAX_LAYERS + 1));
         else if (pick < 8) hgt = lzom_pkg::HGT_W'(-$urandom_range(1, 4));
         else               hgt = lzom_pkg::HGT_W'($urandom);
         issue_command(kind, lid, px, py, hgt);
      end
   endtask

   function automatic void check_field(input string name,
                                       input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         failures++;
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      layer_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_words.size() == 0) begin
            failures++;
            $error("unexpected word: out_id %0d status %0d", rsp_ch.out_id, rsp_ch.status);
         end else begin
            want = owed_words.pop_front();
            check_field("out_id", want.id, rsp_ch.out_id);
            check_field("out_x", want.x, rsp_ch.out_x);
            check_field("out_y", want.y, rsp_ch.out_y);
            check_field("status", want.status, rsp_ch.status);
            check_field("last", want.last, rsp_ch.last);
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0 && idling && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 16);
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      foreach (layer_x[i]) begin
         layer_x[i] = '0;
         layer_y[i] = '0;
      end
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.kind     <= lzom_pkg::KIND_CREATE;
      req_ch.layer_id <= '0;
      req_ch.pos_x    <= '0;
      req_ch.pos_y    <= '0;
      req_ch.height   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_state();
      test_create_layers();
      test_position_moves();
      test_stack_order();
      test_random_traffic(70, 1'b1);
      test_random_traffic(55, 1'b0);
      test_random_traffic(70, 1'b1);
      test_random_traffic(40, 1'b0);

      req_ch.valid <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && owed_words.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
